>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mkd_pkg.sv
package mkd_pkg;

  localparam int unsigned MaxSymbols     = 4;
  localparam int unsigned TickCountWidth = 12;
  localparam int unsigned CfgWidth       = 12;
  localparam int unsigned LetterCount    = 26;

  localparam int unsigned SymCntWidth  = $clog2(MaxSymbols + 2);
  localparam int unsigned SymIdxWidth  = $clog2(MaxSymbols);
  localparam int unsigned CmpWidth     = (TickCountWidth > CfgWidth) ? TickCountWidth : CfgWidth;
  localparam int unsigned KindWidth    = 3;
  localparam int unsigned LetterWidth  = 5;
  localparam int unsigned TotalWidth   = 3;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [TickCountWidth-1:0] TickMax = {TickCountWidth{1'b1}};

  localparam logic [CfgIdxWidth-1:0] CfgIdxDashThreshold = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgIdxLongPress     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgIdxLetterGap     = 2'd2;

  localparam logic [CfgWidth-1:0] DashThresholdReset = 12'd250;
  localparam logic [CfgWidth-1:0] LongPressReset     = 12'd900;
  localparam logic [CfgWidth-1:0] LetterGapReset     = 12'd900;

  typedef enum logic [KindWidth-1:0] {
    EV_DOT      = 3'd0,
    EV_DASH     = 3'd1,
    EV_LETTER   = 3'd2,
    EV_UNKNOWN  = 3'd3,
    EV_TOO_LONG = 3'd4
  } event_kind_e;

  // Letter codes: symbol count and dash pattern, bit i set when symbol i is a dash.
  localparam logic [2:0] CodeLen [LetterCount] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] CodeBits [LetterCount] = '{
    4'h2, 4'h1, 4'h5, 4'h1, 4'h0, 4'h4, 4'h3, 4'h0, 4'h0, 4'hE,
    4'h5, 4'h2, 4'h3, 4'h1, 4'h7, 4'h6, 4'hB, 4'h2, 4'h0, 4'h1,
    4'h4, 4'h8, 4'h6, 4'h9, 4'hD, 4'h3
  };

  typedef struct packed {
    logic [CfgWidth-1:0] dash_threshold_ms;
    logic [CfgWidth-1:0] long_press_limit_ms;
    logic [CfgWidth-1:0] letter_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    event_kind_e            event_kind;
    logic [LetterWidth-1:0] letter_index;
    logic [TotalWidth-1:0]  symbol_total;
  } result_t;

endpackage

>>> hw/rtl/morse_key_decoder_core.sv
// The input beat that causes a result beat is held in the input register, and the
// result beat in the result register.
// Throughput: one button sample per cycle; the input stage stalls only while the
// result register is full and the downstream side holds m_axis_tready low.
// Reset (rst_ni low, asynchronous): registers return to 250/900/900, the press
// and gap counters and the code buffer clear, and both stages empty.
`include "assert_macros.svh"

module morse_key_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [0] button_level
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [2:0] event_kind,
                                                          // [7:3] letter_index,
                                                          // [10:8] symbol_total
  input  logic                             cfg_we_i,
  input  logic [mkd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [mkd_pkg::CfgWidth-1:0]     cfg_data_i
);

  mkd_pkg::cfg_t    cfg;
  mkd_pkg::result_t result;

  logic in_valid_q;
  logic in_level_q;
  logic out_valid_q;
  logic [mkd_pkg::KindWidth-1:0]   out_kind_q;
  logic [mkd_pkg::LetterWidth-1:0] out_letter_q;
  logic [mkd_pkg::TotalWidth-1:0]  out_total_q;
  logic step;

  mkd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mkd_symbol_tracker u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .button_level_i (in_level_q),
    .cfg_i          (cfg),
    .result_o       (result)
  );

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level_q <= s_axis_tdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= result.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && result.valid) begin
      out_kind_q   <= result.event_kind;
      out_letter_q <= result.letter_index;
      out_total_q  <= result.symbol_total;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_total_q, out_letter_q, out_kind_q};

  `MKD_ASSERT(a_ready_when_empty, in_valid_q || s_axis_tready, "Empty input stage refused a beat.")
  `MKD_ASSERT_NEXT(a_stall_keeps_result, out_valid_q && !m_axis_tready, out_valid_q && $stable(out_kind_q), "Stalled result was lost.")

endmodule

>>> hw/rtl/mkd_cfg_regs.sv
module mkd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mkd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [mkd_pkg::CfgWidth-1:0]     cfg_data_i,
  output mkd_pkg::cfg_t                    cfg_o
);

  mkd_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mkd_pkg::CfgIdxDashThreshold: cfg_d.dash_threshold_ms   = cfg_data_i;
        mkd_pkg::CfgIdxLongPress:     cfg_d.long_press_limit_ms = cfg_data_i;
        mkd_pkg::CfgIdxLetterGap:     cfg_d.letter_gap_ms       = cfg_data_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dash_threshold_ms   <= mkd_pkg::DashThresholdReset;
      cfg_q.long_press_limit_ms <= mkd_pkg::LongPressReset;
      cfg_q.letter_gap_ms       <= mkd_pkg::LetterGapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/mkd_letter_match.sv
module mkd_letter_match (
  input  logic [mkd_pkg::SymCntWidth-1:0]  symbol_count_i,
  input  logic [mkd_pkg::MaxSymbols-1:0]   symbol_pattern_i,
  output logic                             found_o,
  output logic [mkd_pkg::LetterWidth-1:0]  letter_index_o
);

  localparam int unsigned CntW = (mkd_pkg::SymCntWidth > 3) ? mkd_pkg::SymCntWidth : 3;
  localparam int unsigned PatW = (mkd_pkg::MaxSymbols > 4) ? mkd_pkg::MaxSymbols : 4;

  logic [CntW-1:0] count_ext;
  logic [PatW-1:0] pattern_ext;

  assign count_ext   = CntW'(symbol_count_i);
  assign pattern_ext = PatW'(symbol_pattern_i);

  // Codes are unique, so at most one entry matches; scan from the top so A wins ties.
  always_comb begin
    found_o        = 1'b0;
    letter_index_o = '0;
    for (int i = mkd_pkg::LetterCount - 1; i >= 0; i--) begin
      if (count_ext == CntW'(mkd_pkg::CodeLen[i]) &&
          pattern_ext == PatW'(mkd_pkg::CodeBits[i])) begin
        found_o        = 1'b1;
        letter_index_o = mkd_pkg::LetterWidth'(i);
      end
    end
  end

endmodule

>>> hw/rtl/mkd_symbol_tracker.sv
`include "assert_macros.svh"

module mkd_symbol_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             button_level_i,
  input  mkd_pkg::cfg_t    cfg_i,
  output mkd_pkg::result_t result_o
);

  localparam int unsigned TW = mkd_pkg::TickCountWidth;
  localparam int unsigned CW = mkd_pkg::CmpWidth;
  localparam logic [mkd_pkg::SymCntWidth-1:0] MaxCnt =
    mkd_pkg::SymCntWidth'(mkd_pkg::MaxSymbols);

  logic                             was_pressed_d, was_pressed_q;
  logic [TW-1:0]                    press_ticks_d, press_ticks_q;
  logic [TW-1:0]                    gap_ticks_d, gap_ticks_q;
  logic [mkd_pkg::MaxSymbols-1:0]   symbol_pattern_d, symbol_pattern_q;
  logic [mkd_pkg::SymCntWidth-1:0]  symbol_count_d, symbol_count_q;

  logic                             is_dash;
  logic [TW-1:0]                    gap_inc;
  logic                             found;
  logic [mkd_pkg::LetterWidth-1:0]  letter_index;

  mkd_letter_match u_match (
    .symbol_count_i   (symbol_count_q),
    .symbol_pattern_i (symbol_pattern_q),
    .found_o          (found),
    .letter_index_o   (letter_index)
  );

  assign is_dash = CW'(press_ticks_q) >= CW'(cfg_i.dash_threshold_ms);
  assign gap_inc = (gap_ticks_q != mkd_pkg::TickMax) ? gap_ticks_q + 1'b1 : gap_ticks_q;

  always_comb begin
    was_pressed_d    = was_pressed_q;
    press_ticks_d    = press_ticks_q;
    gap_ticks_d      = gap_ticks_q;
    symbol_pattern_d = symbol_pattern_q;
    symbol_count_d   = symbol_count_q;
    result_o         = '0;
    result_o.event_kind = mkd_pkg::EV_DOT;

    if (button_level_i) begin
      if (was_pressed_q) begin
        if (press_ticks_q != mkd_pkg::TickMax) begin
          press_ticks_d = press_ticks_q + 1'b1;
        end
      end else begin
        press_ticks_d = TW'(1);
      end
      was_pressed_d = 1'b1;
    end else if (was_pressed_q) begin
      was_pressed_d   = 1'b0;
      press_ticks_d   = '0;
      gap_ticks_d     = '0;
      result_o.valid  = 1'b1;
      if (CW'(press_ticks_q) > CW'(cfg_i.long_press_limit_ms)) begin
        symbol_pattern_d    = '0;
        symbol_count_d      = '0;
        result_o.event_kind = mkd_pkg::EV_TOO_LONG;
      end else begin
        if (symbol_count_q < MaxCnt) begin
          symbol_pattern_d[symbol_count_q[mkd_pkg::SymIdxWidth-1:0]] = is_dash;
          symbol_count_d = symbol_count_q + 1'b1;
        end else begin
          symbol_count_d = MaxCnt + 1'b1;
        end
        result_o.event_kind   = is_dash ? mkd_pkg::EV_DASH : mkd_pkg::EV_DOT;
        result_o.symbol_total = symbol_count_d[mkd_pkg::TotalWidth-1:0];
      end
    end else begin
      gap_ticks_d = gap_inc;
      if (CW'(gap_inc) > CW'(cfg_i.letter_gap_ms) && symbol_count_q != '0) begin
        symbol_pattern_d    = '0;
        symbol_count_d      = '0;
        result_o.valid      = 1'b1;
        result_o.event_kind = found ? mkd_pkg::EV_LETTER : mkd_pkg::EV_UNKNOWN;
        result_o.letter_index = found ? letter_index : '0;
      end
    end

    if (!step_i) begin
      result_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q    <= 1'b0;
      press_ticks_q    <= '0;
      gap_ticks_q      <= '0;
      symbol_pattern_q <= '0;
      symbol_count_q   <= '0;
    end else if (step_i) begin
      was_pressed_q    <= was_pressed_d;
      press_ticks_q    <= press_ticks_d;
      gap_ticks_q      <= gap_ticks_d;
      symbol_pattern_q <= symbol_pattern_d;
      symbol_count_q   <= symbol_count_d;
    end
  end

  `MKD_ASSERT(a_count_range, symbol_count_q <= MaxCnt + 1'b1, "Symbol count beyond overflow mark.")
  `MKD_ASSERT(a_empty_pattern, symbol_count_q != '0 || symbol_pattern_q == '0, "Empty code has dash bits.")
  `MKD_ASSERT(a_press_nonzero, !was_pressed_q || press_ticks_q != '0, "Held press with zero length.")
  `MKD_ASSERT_NEXT(a_release_clears, step_i && !button_level_i && was_pressed_q, !was_pressed_q && press_ticks_q == '0 && gap_ticks_q == '0, "Release did not restart counters.")

endmodule
